// ===== src/bilinear_height_grid_sampler_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Bilinear height grid sampler assertion macros
// Checks that simulation builds keep and synthesis builds drop.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_HEIGHT_GRID_SAMPLER_UNIT_DEFINES_SVH
`define BILINEAR_HEIGHT_GRID_SAMPLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication on clk, masked during reset
`define HGS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hgs assertion failed");

// next-cycle implication on clk, masked during reset
`define HGS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hgs assertion failed");

`else

`define HGS_ASSERT_IMP(lbl, ante, cons)
`define HGS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== src/hgs_pkg.sv =====
// ----------------------------------------------------------------------------
// Height grid sampler package
// Shared item type and register index codes.
// ----------------------------------------------------------------------------
package hgs_pkg;

	// register indexes of the configuration port
	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd1;
	localparam logic [2:0] REG_SPACING  = 3'd2;
	localparam logic [2:0] REG_FLAT     = 3'd3;
	localparam logic [2:0] REG_VALID    = 3'd4;

	// control part of one word moving down the pipeline
	typedef struct packed {
		logic        v;
		logic        func;
		logic        wr_ok;
		logic        fb;
		logic [3:0]  col;
		logic [3:0]  row;
		logic [31:0] wdata;
	} item_t;

endpackage

// ===== src/hgs_if.sv =====
// ----------------------------------------------------------------------------
// Height grid sampler channels
// Request and response valid/ready channels.
// ----------------------------------------------------------------------------
interface hgs_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [3:0]         cell_column;
	logic [3:0]         cell_row;
	logic signed [31:0] cell_height;
	logic signed [31:0] query_x;
	logic signed [31:0] query_z;

	modport source (output valid, func, cell_column, cell_row, cell_height, query_x,
		query_z, input ready);
	modport sink (input valid, func, cell_column, cell_row, cell_height, query_x,
		query_z, output ready);
endinterface

interface hgs_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] ground_height;
	logic               from_grid;

	modport source (output valid, ground_height, from_grid, input ready);
	modport sink (input valid, ground_height, from_grid, output ready);
endinterface

// ===== src/bilinear_height_grid_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// Bilinear height grid sampler
// Cell writes and height queries over a square Q23.8 height grid.
// ----------------------------------------------------------------------------
// Takes one word per cycle while no response is stalled, writes and queries mixed
// freely; a query passes stage 1, the grid position divider with its delay line,
// the range check, the grid read, the blend and the response register. The divider
// resolves one quotient bit per stage, QB being the quotient width clog2((GRID_SIZE-1)*256+1).
// Cell writes take effect at the grid read stage, so they keep order with queries
// around them. A stalled response holds the whole pipeline.
`include "bilinear_height_grid_sampler_unit_defines.svh"

module bilinear_height_grid_sampler_unit #(
	parameter int GRID_SIZE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	hgs_in_if.sink      req,
	hgs_out_if.source   rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);
	import hgs_pkg::*;

	localparam int LIM = (GRID_SIZE - 1) * 256;
	localparam int QB  = $clog2(LIM + 1);
	localparam int XW  = QB - 8;
	localparam int D   = GRID_SIZE * GRID_SIZE;
	localparam int AW  = $clog2(D);

	logic signed [31:0] ox_q, oz_q, sp_q, flat_q;
	logic               gv_q;
	logic               adv;

	item_t              it_s1;
	logic signed [32:0] dx_s1, dz_s1;
	item_t              it_d [QB+1];
	logic [QB-1:0]      fx, fz;
	logic               outx, outz;

	item_t              it_sf;
	logic               in_sf;
	logic [XW-1:0]      x0_sf, z0_sf;
	logic [8:0]         tx_sf, tz_sf;
	logic [XW-1:0]      x0c, z0c;
	logic [AW-1:0]      base, waddr;
	logic               we;

	item_t              it_m1, it_l1, it_l2, it_l3;
	logic               in_m1, in_l1, in_l2, in_l3;
	logic [8:0]         tx_m1, tz_m1;
	logic [31:0]        h00, h10, h01, h11;
	logic signed [31:0] lerp_h;

	logic               out_v_q;
	logic signed [31:0] out_h_q;
	logic               out_g_q;

	// pipeline moves unless a response is stuck
	assign adv       = !out_v_q || rsp.ready;
	assign req.ready = adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q   <= '0;
			oz_q   <= '0;
			sp_q   <= '0;
			flat_q <= '0;
			gv_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ORIGIN_X: ox_q   <= cfg_wdata;
				REG_ORIGIN_Z: oz_q   <= cfg_wdata;
				REG_SPACING:  sp_q   <= cfg_wdata;
				REG_FLAT:     flat_q <= cfg_wdata;
				REG_VALID:    gv_q   <= cfg_wdata[0];
				default:      ;
			endcase
		end
	end

	// stage 1: capture word, offsets from origin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_s1 <= '0;
			dx_s1 <= '0;
			dz_s1 <= '0;
		end else if (adv) begin
			it_s1.v     <= req.valid;
			it_s1.func  <= req.func;
			it_s1.wr_ok <= (32'(req.cell_column) < 32'(GRID_SIZE)) &&
				(32'(req.cell_row) < 32'(GRID_SIZE));
			it_s1.fb    <= !(gv_q && !sp_q[31] && (sp_q != '0));
			it_s1.col   <= req.cell_column;
			it_s1.row   <= req.cell_row;
			it_s1.wdata <= req.cell_height;
			dx_s1       <= 33'(req.query_x) - 33'(ox_q);
			dz_s1       <= 33'(req.query_z) - 33'(oz_q);
		end
	end

	// grid position dividers
	hgs_div #(.QB(QB)) u_div_x (
		.clk     (clk),
		.en      (adv),
		.delta   (dx_s1),
		.spacing (sp_q[30:0]),
		.pos     (fx),
		.outside (outx)
	);

	hgs_div #(.QB(QB)) u_div_z (
		.clk     (clk),
		.en      (adv),
		.delta   (dz_s1),
		.spacing (sp_q[30:0]),
		.pos     (fz),
		.outside (outz)
	);

	// control delay line alongside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) begin
				it_d[k] <= '0;
			end
		end else if (adv) begin
			it_d[0] <= it_s1;
			for (int k = 1; k <= QB; k++) begin
				it_d[k] <= it_d[k-1];
			end
		end
	end

	// base cell clamped to the last full cell
	assign x0c = (int'(fx[QB-1:8]) > GRID_SIZE - 2) ? XW'(GRID_SIZE - 2) : fx[QB-1:8];
	assign z0c = (int'(fz[QB-1:8]) > GRID_SIZE - 2) ? XW'(GRID_SIZE - 2) : fz[QB-1:8];

	// stage f: range check and cell weights
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_sf <= '0;
			in_sf <= 1'b0;
			x0_sf <= '0;
			z0_sf <= '0;
			tx_sf <= '0;
			tz_sf <= '0;
		end else if (adv) begin
			it_sf <= it_d[QB];
			in_sf <= !it_d[QB].fb && !outx && !outz && (int'(fx) <= LIM) &&
				(int'(fz) <= LIM);
			x0_sf <= x0c;
			z0_sf <= z0c;
			tx_sf <= 9'(fx - QB'({x0c, 8'h00}));
			tz_sf <= 9'(fz - QB'({z0c, 8'h00}));
		end
	end

	// grid addresses, writes land here in order with reads
	assign base  = AW'(int'(z0_sf) * GRID_SIZE + int'(x0_sf));
	assign waddr = AW'(int'(it_sf.row) * GRID_SIZE + int'(it_sf.col));
	assign we    = adv && it_sf.v && !it_sf.func && it_sf.wr_ok;

	// one grid copy per corner
	hgs_ram #(.W(32), .D(D)) u_ram_00 (
		.clk(clk), .we(we), .waddr(waddr), .wdata(it_sf.wdata),
		.re(adv), .raddr(base), .rdata(h00)
	);

	hgs_ram #(.W(32), .D(D)) u_ram_10 (
		.clk(clk), .we(we), .waddr(waddr), .wdata(it_sf.wdata),
		.re(adv), .raddr(AW'(base + AW'(1))), .rdata(h10)
	);

	hgs_ram #(.W(32), .D(D)) u_ram_01 (
		.clk(clk), .we(we), .waddr(waddr), .wdata(it_sf.wdata),
		.re(adv), .raddr(AW'(base + AW'(GRID_SIZE))), .rdata(h01)
	);

	hgs_ram #(.W(32), .D(D)) u_ram_11 (
		.clk(clk), .we(we), .waddr(waddr), .wdata(it_sf.wdata),
		.re(adv), .raddr(AW'(base + AW'(GRID_SIZE + 1))), .rdata(h11)
	);

	// stage m1 through l3: control beside the grid read and blend
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_m1 <= '0;
			it_l1 <= '0;
			it_l2 <= '0;
			it_l3 <= '0;
			in_m1 <= 1'b0;
			in_l1 <= 1'b0;
			in_l2 <= 1'b0;
			in_l3 <= 1'b0;
			tx_m1 <= '0;
			tz_m1 <= '0;
		end else if (adv) begin
			it_m1 <= it_sf;
			it_l1 <= it_m1;
			it_l2 <= it_l1;
			it_l3 <= it_l2;
			in_m1 <= in_sf;
			in_l1 <= in_m1;
			in_l2 <= in_l1;
			in_l3 <= in_l2;
			tx_m1 <= tx_sf;
			tz_m1 <= tz_sf;
		end
	end

	hgs_lerp u_lerp (
		.clk    (clk),
		.en     (adv),
		.h00    (h00),
		.h10    (h10),
		.h01    (h01),
		.h11    (h11),
		.tx     (tx_m1),
		.tz     (tz_m1),
		.height (lerp_h)
	);

	// response register, queries only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			out_h_q <= '0;
			out_g_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= it_l3.v && it_l3.func;
			out_h_q <= in_l3 ? lerp_h : flat_q;
			out_g_q <= in_l3;
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.ground_height = out_h_q;
	assign rsp.from_grid     = out_g_q;

	// a stuck response blocks new words
	`HGS_ASSERT_IMP(a_stall_blocks, rsp.valid && !rsp.ready, !req.ready)
	// cell writes never reach the response
	`HGS_ASSERT_NXT(a_write_silent, adv && it_l3.v && !it_l3.func, !out_v_q)
	// grid answers only with a usable grid
	`HGS_ASSERT_IMP(a_grid_usable, out_v_q && out_g_q,
		gv_q && !sp_q[31] && (sp_q != '0))

endmodule

// ===== src/hgs_ram.sv =====
// ----------------------------------------------------------------------------
// Height grid sampler RAM
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hgs_ram #(
	parameter int W = 32,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/hgs_div.sv =====
// ----------------------------------------------------------------------------
// Height grid sampler position divider
// Pipelined restoring divide of (delta * 256) by the spacing, one bit a stage.
// ----------------------------------------------------------------------------
module hgs_div #(
	parameter int QB = 12
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [32:0] delta,
	input  logic [30:0]        spacing,
	output logic [QB-1:0]      pos,
	output logic               outside
);

	localparam int DW = ((41 > 31 + QB) ? 41 : 31 + QB) + 1;

	logic [32:0]   mag;
	logic [DW-1:0] num;
	logic [DW-1:0] rem_p;
	logic          neg_p;
	logic          oob_p;
	logic [DW-1:0] rem_sk [QB];
	logic [QB-1:0] q_sk   [QB];
	logic          neg_sk [QB];
	logic          oob_sk [QB];

	// magnitude of the scaled delta
	assign mag = delta[32] ? 33'(-delta) : 33'(delta);
	assign num = DW'({mag, 8'h00});

	// prep stage: sign and quotient overflow check
	always_ff @(posedge clk) begin
		if (en) begin
			rem_p <= num;
			neg_p <= delta[32];
			oob_p <= num >= (DW'(spacing) << QB);
		end
	end

	// one quotient bit per stage, msb first
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QB; k++) begin
				logic [DW-1:0] r_in;
				logic [QB-1:0] q_in;
				logic [DW-1:0] d;
				r_in = (k == 0) ? rem_p : rem_sk[(k == 0) ? 0 : k - 1];
				q_in = (k == 0) ? '0 : q_sk[(k == 0) ? 0 : k - 1];
				d = DW'(spacing) << (QB - 1 - k);
				if (r_in >= d) begin
					rem_sk[k] <= r_in - d;
					q_sk[k]   <= q_in | (QB'(1) << (QB - 1 - k));
				end else begin
					rem_sk[k] <= r_in;
					q_sk[k]   <= q_in;
				end
				neg_sk[k] <= (k == 0) ? neg_p : neg_sk[(k == 0) ? 0 : k - 1];
				oob_sk[k] <= (k == 0) ? oob_p : oob_sk[(k == 0) ? 0 : k - 1];
			end
		end
	end

	// a negative delta stays inside only when it truncates to zero
	assign pos     = q_sk[QB-1];
	assign outside = oob_sk[QB-1] | (neg_sk[QB-1] & (|q_sk[QB-1]));

endmodule

// ===== src/hgs_lerp.sv =====
// ----------------------------------------------------------------------------
// Height grid sampler blend pipeline
// Bilinear blend of four corners in three register stages.
// ----------------------------------------------------------------------------
module hgs_lerp (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] h00,
	input  logic signed [31:0] h10,
	input  logic signed [31:0] h01,
	input  logic signed [31:0] h11,
	input  logic [8:0]         tx,
	input  logic [8:0]         tz,
	output logic signed [31:0] height
);

	logic signed [42:0] p0_l1, p1_l1;
	logic signed [31:0] h00_l1, h01_l1;
	logic [8:0]         tz_l1, tz_l2;
	logic signed [31:0] a_l2, b_l2, a_l3;
	logic signed [42:0] p_l3;
	logic signed [32:0] d0, d1, d2;

	// divide by 256 truncating toward zero
	function automatic logic signed [42:0] div256(input logic signed [42:0] p);
		logic signed [42:0] t;
		t = p + (p[42] ? 43'sd255 : 43'sd0);
		return t >>> 8;
	endfunction

	assign d0 = 33'(h10) - 33'(h00);
	assign d1 = 33'(h11) - 33'(h01);
	assign d2 = 33'(b_l2) - 33'(a_l2);

	// stage 1: edge differences times x weight
	always_ff @(posedge clk) begin
		if (en) begin
			p0_l1  <= 43'(d0 * $signed({1'b0, tx}));
			p1_l1  <= 43'(d1 * $signed({1'b0, tx}));
			h00_l1 <= h00;
			h01_l1 <= h01;
			tz_l1  <= tz;
		end
	end

	// stage 2: near and far edge heights
	always_ff @(posedge clk) begin
		if (en) begin
			a_l2  <= 32'(43'(h00_l1) + div256(p0_l1));
			b_l2  <= 32'(43'(h01_l1) + div256(p1_l1));
			tz_l2 <= tz_l1;
		end
	end

	// stage 3: difference times z weight
	always_ff @(posedge clk) begin
		if (en) begin
			p_l3 <= 43'(d2 * $signed({1'b0, tz_l2}));
			a_l3 <= a_l2;
		end
	end

	assign height = 32'(43'(a_l3) + div256(p_l3));

endmodule
